// File: rtl/core/hdp_pkg.sv
// Shared types, constants and literal tables for the HTTP request head parser.
`default_nettype none

package hdp_pkg;

  // Fixed field widths.
  localparam int unsigned DataW = 8;
  localparam int unsigned LimW = 13;
  localparam int unsigned NameLimW = 9;
  localparam int unsigned MaxFieldBytes = 4096;
  localparam int unsigned FcW = $clog2(MaxFieldBytes);
  localparam int unsigned PosW = 12;
  localparam int unsigned EvW = 4;
  localparam int unsigned MethW = 3;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgUriLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNameLimit = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgValueLimit = 2'd2;

  localparam logic [LimW-1:0] UriLimitRst = 13'd256;
  localparam logic [NameLimW-1:0] NameLimitRst = 9'd64;
  localparam logic [LimW-1:0] ValueLimitRst = 13'd256;

  // Literal selections.
  localparam logic [3:0] SelConnect = 4'd0;
  localparam logic [3:0] SelGet = 4'd1;
  localparam logic [3:0] SelHead = 4'd2;
  localparam logic [3:0] SelOptions = 4'd3;
  localparam logic [3:0] SelTrace = 4'd4;
  localparam logic [3:0] SelPatch = 4'd5;
  localparam logic [3:0] SelPost = 4'd6;
  localparam logic [3:0] SelPut = 4'd7;
  localparam logic [3:0] SelVersion = 4'd8;
  localparam logic [3:0] NumLits = 4'd9;

  // Method codes.
  localparam logic [MethW-1:0] MethGet = 3'd0;
  localparam logic [MethW-1:0] MethHead = 3'd1;
  localparam logic [MethW-1:0] MethOptions = 3'd2;
  localparam logic [MethW-1:0] MethTrace = 3'd3;
  localparam logic [MethW-1:0] MethPatch = 3'd4;
  localparam logic [MethW-1:0] MethPost = 3'd5;
  localparam logic [MethW-1:0] MethPut = 3'd6;

  localparam logic [DataW-1:0] ChLf = 8'h0A;
  localparam logic [DataW-1:0] ChNul = 8'h00;
  localparam logic [DataW-1:0] ChSpace = 8'h20;
  localparam logic [DataW-1:0] ChColon = 8'h3A;

  typedef enum logic [EvW-1:0] {
    EV_CONSUMED   = 4'd0,
    EV_METHOD     = 4'd1,
    EV_URI_BYTE   = 4'd2,
    EV_URI_END    = 4'd3,
    EV_NAME_BYTE  = 4'd4,
    EV_NAME_END   = 4'd5,
    EV_VALUE_BYTE = 4'd6,
    EV_HDR_END    = 4'd7,
    EV_HDRS_DONE  = 4'd8,
    EV_ERROR      = 4'd9,
    EV_IDLE       = 4'd10
  } event_t;

  // Verdict of one byte against a delimited, bounded field.
  typedef enum logic [1:0] {
    FV_ERROR = 2'd0,
    FV_DATA  = 2'd1,
    FV_DELIM = 2'd2
  } field_verdict_t;

  function automatic logic [3:0] hdp_lit_len(input logic [3:0] sel);
    logic [3:0] len;
    begin
      unique case (sel)
        SelConnect: len = 4'd7;
        SelGet:     len = 4'd3;
        SelHead:    len = 4'd4;
        SelOptions: len = 4'd7;
        SelTrace:   len = 4'd5;
        SelPatch:   len = 4'd4;
        SelPost:    len = 4'd3;
        SelPut:     len = 4'd2;
        SelVersion: len = 4'd9;
        default:    len = 4'd0;
      endcase
      return len;
    end
  endfunction

  function automatic logic [MethW-1:0] hdp_lit_method(input logic [3:0] sel);
    logic [MethW-1:0] meth;
    begin
      unique case (sel)
        SelConnect: meth = MethGet;
        SelGet:     meth = MethGet;
        SelHead:    meth = MethHead;
        SelOptions: meth = MethOptions;
        SelTrace:   meth = MethTrace;
        SelPatch:   meth = MethPatch;
        SelPost:    meth = MethPost;
        SelPut:     meth = MethPut;
        default:    meth = MethGet;
      endcase
      return meth;
    end
  endfunction

  // Character idx of literal sel. The text sits right-aligned, so the first
  // character is the most significant one in use.
  function automatic logic [DataW-1:0] hdp_lit_char(input logic [3:0] sel,
                                                    input logic [3:0] idx);
    logic [79:0] text;
    logic [3:0] len;
    logic [6:0] shift;
    begin
      len = hdp_lit_len(sel);
      unique case (sel)
        SelConnect: text = 80'("ONNECT ");
        SelGet:     text = 80'("ET ");
        SelHead:    text = 80'("EAD ");
        SelOptions: text = 80'("PTIONS ");
        SelTrace:   text = 80'("RACE ");
        SelPatch:   text = 80'("TCH ");
        SelPost:    text = 80'("ST ");
        SelPut:     text = 80'("T ");
        SelVersion: text = 80'("HTTP/1.0\n");
        default:    text = '0;
      endcase
      shift = {3'd0, 4'(len - 4'd1 - idx)} << 3;
      return (idx < len) ? DataW'(text >> shift) : ChNul;
    end
  endfunction

  function automatic logic [LimW-1:0] hdp_clamp(input logic [LimW-1:0] v);
    return (v > LimW'(MaxFieldBytes)) ? LimW'(MaxFieldBytes) : v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/hdp_field_check.sv
// Classifies one byte of a bounded field: data byte, delimiter or error.
`default_nettype none

module hdp_field_check (
  input  wire logic [hdp_pkg::FcW-1:0]   count,
  input  wire logic [hdp_pkg::LimW-1:0]  limit,
  input  wire logic [hdp_pkg::DataW-1:0] delim,
  input  wire logic [hdp_pkg::DataW-1:0] data,
  output hdp_pkg::field_verdict_t        verdict
);
  import hdp_pkg::*;

  logic [LimW-1:0] count_ext;
  logic [LimW-1:0] count_inc;

  assign count_ext = LimW'(count);
  assign count_inc = count_ext + LimW'(1);

  // A data byte must leave room for the delimiter within the limit.
  always_comb begin
    priority if (count_ext >= limit) begin
      verdict = FV_ERROR;
    end else if (data == delim) begin
      verdict = FV_DELIM;
    end else if (data == ChLf || data == ChNul) begin
      verdict = FV_ERROR;
    end else if (count_inc >= limit) begin
      verdict = FV_ERROR;
    end else begin
      verdict = FV_DATA;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/http_request_head_parser_core.sv
// HTTP/1.0 request head parser: one byte in, one event word out.
//
// Input channel: in_valid / in_stall carry one stream byte per word together
// with in_restart, which returns the parser to the start of a request before
// that byte is handled. Result channel: out_valid / out_stall carry one event
// word per input word (event code, data byte, field offset, held method).
// Configuration: cfg_wr_en writes cfg_wr_data into the limit named by
// cfg_index (0 URI, 1 header name, 2 header value); other indexes are dropped.
// The event for a byte is in the output register on the clock after that byte is
// taken. Throughput is one byte per cycle while in_stall stays low; the parse
// state and the event are both computed combinationally between the input
// ports and the output register.
// in_stall is raised only while the output register holds a word and the
// receiver stalls; a word is taken in the same cycle that the held one drains.
// Reset (rst_n low, synchronous) empties the output register, returns the
// parser to the method letter and loads the default limits 256, 64 and 256.
// There is no clearing pass after reset.
`default_nettype none

module http_request_head_parser_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic [hdp_pkg::DataW-1:0]        in_data_byte,
  input  wire logic                             in_restart,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic [hdp_pkg::EvW-1:0]          out_event_res,
  output      logic [hdp_pkg::DataW-1:0]        out_out_byte,
  output      logic [hdp_pkg::PosW-1:0]         out_position,
  output      logic [hdp_pkg::MethW-1:0]        out_method_code,
  input  wire logic                             cfg_wr_en,
  input  wire logic [hdp_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [hdp_pkg::LimW-1:0]         cfg_wr_data
);
  import hdp_pkg::*;

  typedef enum logic [3:0] {
    PH_M0     = 4'd0,
    PH_M1     = 4'd1,
    PH_LIT    = 4'd2,
    PH_URI    = 4'd3,
    PH_HSTART = 4'd4,
    PH_NAME   = 4'd5,
    PH_VALUE  = 4'd6,
    PH_DONE   = 4'd7,
    PH_ERR    = 4'd8
  } phase_t;

  phase_t            phase_r, phase_nxt, cur_phase;
  logic [3:0]        sel_r, sel_nxt, cur_sel;
  logic [3:0]        idx_r, idx_nxt, cur_idx;
  logic [FcW-1:0]    fc_r, fc_nxt, cur_fc;
  logic [MethW-1:0]  meth_r, meth_nxt, cur_meth;

  logic [LimW-1:0]     uri_limit_r;
  logic [NameLimW-1:0] name_limit_r;
  logic [LimW-1:0]     value_limit_r;

  logic              out_valid_r;
  event_t            ev_r, ev_nxt;
  logic [DataW-1:0]  ob_r, ob_nxt;
  logic [PosW-1:0]   pos_r, pos_nxt;
  logic [MethW-1:0]  meth_out_r;

  logic              accept;
  logic [DataW-1:0]  c;
  logic [3:0]        lit_len;
  logic [DataW-1:0]  lit_ch;
  logic              lit_bad;
  logic [LimW-1:0]   name_clamped;
  logic [LimW-1:0]   chk_limit;
  logic [DataW-1:0]  chk_delim;
  field_verdict_t    verdict;
  logic [LimW-1:0]   fc_inc;

  assign in_stall = out_valid_r & out_stall;
  assign accept = in_valid & ~in_stall;
  assign c = in_data_byte;

  // Restart applies before the byte is handled.
  assign cur_phase = in_restart ? PH_M0 : phase_r;
  assign cur_sel = in_restart ? '0 : sel_r;
  assign cur_idx = in_restart ? '0 : idx_r;
  assign cur_fc = in_restart ? '0 : fc_r;
  assign cur_meth = in_restart ? '0 : meth_r;

  assign lit_len = hdp_lit_len(cur_sel);
  assign lit_ch = hdp_lit_char(cur_sel, cur_idx);
  assign lit_bad = (cur_sel >= NumLits) || (cur_idx >= lit_len) || (lit_ch != c);

  // The name limit counts the first byte, which is taken in the line start.
  assign name_clamped = hdp_clamp(LimW'(name_limit_r));

  always_comb begin
    unique case (cur_phase)
      PH_URI: begin
        chk_limit = hdp_clamp(uri_limit_r);
        chk_delim = ChSpace;
      end
      PH_NAME: begin
        chk_limit = (name_clamped != '0) ? name_clamped - LimW'(1) : '0;
        chk_delim = ChColon;
      end
      default: begin
        chk_limit = hdp_clamp(value_limit_r);
        chk_delim = ChLf;
      end
    endcase
  end

  hdp_field_check u_field_check (
    .count   (cur_fc),
    .limit   (chk_limit),
    .delim   (chk_delim),
    .data    (c),
    .verdict (verdict)
  );

  assign fc_inc = LimW'(cur_fc) + LimW'(1);

  always_comb begin
    phase_nxt = cur_phase;
    sel_nxt = cur_sel;
    idx_nxt = cur_idx;
    fc_nxt = cur_fc;
    meth_nxt = cur_meth;
    ev_nxt = EV_CONSUMED;
    ob_nxt = '0;
    pos_nxt = '0;
    unique case (cur_phase)
      PH_M0: begin
        priority if (c == "C") begin
          sel_nxt = SelConnect;
        end else if (c == "G") begin
          sel_nxt = SelGet;
        end else if (c == "H") begin
          sel_nxt = SelHead;
        end else if (c == "O") begin
          sel_nxt = SelOptions;
        end else if (c == "T") begin
          sel_nxt = SelTrace;
        end else begin
          sel_nxt = cur_sel;
        end
        if (c == "C" || c == "G" || c == "H" || c == "O" || c == "T") begin
          idx_nxt = '0;
          meth_nxt = hdp_lit_method(sel_nxt);
          phase_nxt = PH_LIT;
        end else if (c == "P") begin
          phase_nxt = PH_M1;
        end else begin
          phase_nxt = PH_ERR;
          ev_nxt = EV_ERROR;
        end
      end
      PH_M1: begin
        priority if (c == "A") begin
          sel_nxt = SelPatch;
        end else if (c == "O") begin
          sel_nxt = SelPost;
        end else if (c == "U") begin
          sel_nxt = SelPut;
        end else begin
          sel_nxt = cur_sel;
        end
        if (c == "A" || c == "O" || c == "U") begin
          idx_nxt = '0;
          meth_nxt = hdp_lit_method(sel_nxt);
          phase_nxt = PH_LIT;
        end else begin
          phase_nxt = PH_ERR;
          ev_nxt = EV_ERROR;
        end
      end
      PH_LIT: begin
        priority if (lit_bad) begin
          phase_nxt = PH_ERR;
          ev_nxt = EV_ERROR;
        end else if (cur_idx + 4'd1 == lit_len) begin
          fc_nxt = '0;
          if (cur_sel == SelVersion) begin
            phase_nxt = PH_HSTART;
          end else begin
            phase_nxt = PH_URI;
            ev_nxt = EV_METHOD;
          end
        end else begin
          idx_nxt = cur_idx + 4'd1;
        end
      end
      PH_URI: begin
        unique case (verdict)
          FV_DELIM: begin
            ev_nxt = EV_URI_END;
            pos_nxt = PosW'(cur_fc);
            sel_nxt = SelVersion;
            idx_nxt = '0;
            phase_nxt = PH_LIT;
          end
          FV_DATA: begin
            ev_nxt = EV_URI_BYTE;
            ob_nxt = c;
            pos_nxt = PosW'(cur_fc);
            fc_nxt = FcW'(fc_inc);
          end
          default: begin
            phase_nxt = PH_ERR;
            ev_nxt = EV_ERROR;
          end
        endcase
      end
      PH_HSTART: begin
        if (c == ChLf) begin
          ev_nxt = EV_HDRS_DONE;
          phase_nxt = PH_DONE;
        end else begin
          ev_nxt = EV_NAME_BYTE;
          ob_nxt = c;
          fc_nxt = '0;
          phase_nxt = PH_NAME;
        end
      end
      PH_NAME: begin
        unique case (verdict)
          FV_DELIM: begin
            ev_nxt = EV_NAME_END;
            pos_nxt = PosW'(fc_inc);
            fc_nxt = '0;
            phase_nxt = PH_VALUE;
          end
          FV_DATA: begin
            ev_nxt = EV_NAME_BYTE;
            ob_nxt = c;
            pos_nxt = PosW'(fc_inc);
            fc_nxt = FcW'(fc_inc);
          end
          default: begin
            phase_nxt = PH_ERR;
            ev_nxt = EV_ERROR;
          end
        endcase
      end
      PH_VALUE: begin
        unique case (verdict)
          FV_DELIM: begin
            ev_nxt = EV_HDR_END;
            pos_nxt = PosW'(cur_fc);
            fc_nxt = '0;
            phase_nxt = PH_HSTART;
          end
          FV_DATA: begin
            ev_nxt = EV_VALUE_BYTE;
            ob_nxt = c;
            pos_nxt = PosW'(cur_fc);
            fc_nxt = FcW'(fc_inc);
          end
          default: begin
            phase_nxt = PH_ERR;
            ev_nxt = EV_ERROR;
          end
        endcase
      end
      PH_DONE: begin
        ev_nxt = EV_IDLE;
      end
      default: begin
        phase_nxt = PH_ERR;
        ev_nxt = EV_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_M0;
      sel_r <= '0;
      idx_r <= '0;
      fc_r <= '0;
      meth_r <= '0;
      out_valid_r <= 1'b0;
      uri_limit_r <= UriLimitRst;
      name_limit_r <= NameLimitRst;
      value_limit_r <= ValueLimitRst;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        sel_r <= sel_nxt;
        idx_r <= idx_nxt;
        fc_r <= fc_nxt;
        meth_r <= meth_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CfgUriLimit:   uri_limit_r <= cfg_wr_data;
          CfgNameLimit:  name_limit_r <= NameLimW'(cfg_wr_data);
          CfgValueLimit: value_limit_r <= cfg_wr_data;
          default: begin
          end
        endcase
      end
    end
    if (accept) begin
      ev_r <= ev_nxt;
      ob_r <= ob_nxt;
      pos_r <= pos_nxt;
      meth_out_r <= meth_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_event_res = ev_r;
  assign out_out_byte = ob_r;
  assign out_position = pos_r;
  assign out_method_code = meth_out_r;

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the HTTP request head parser core.
`default_nettype none

module tb;
  import hdp_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int NumSets = 8;
  localparam int WordsPerSet = 160;

  typedef enum logic [3:0] {
    P_METH0, P_METH1, P_TEXT, P_URI, P_LINE, P_NAME, P_VALUE, P_DONE, P_ERR
  } parse_phase_t;

  typedef struct packed {
    event_t            ev;
    logic [DataW-1:0]  ob;
    logic [PosW-1:0]   pos;
    logic [MethW-1:0]  meth;
  } head_event_t;

  typedef struct {
    logic [DataW-1:0] data;
    logic             rs;
    logic             pinned;
    head_event_t      word;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [DataW-1:0] in_data_byte = '0;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [EvW-1:0] out_event_res;
  logic [DataW-1:0] out_out_byte;
  logic [PosW-1:0] out_position;
  logic [MethW-1:0] out_method_code;
  logic cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [LimW-1:0] cfg_wr_data = '0;

  // Hand-typed expectation that travels with a table word.
  logic pin_on = 1'b0;
  head_event_t pin_word = '0;

  // Parser state as the predictor sees it.
  parse_phase_t p_phase = P_METH0;
  logic [3:0] p_sel = '0;
  logic [3:0] p_idx = '0;
  logic [LimW-1:0] p_cnt = '0;
  logic [MethW-1:0] p_meth = MethGet;
  logic [LimW-1:0] lim_uri = UriLimitRst;
  logic [NameLimW-1:0] lim_name = NameLimitRst;
  logic [LimW-1:0] lim_value = ValueLimitRst;

  string lit_text [0:8] = '{"ONNECT ", "ET ", "EAD ", "PTIONS ", "RACE ", "TCH ",
                            "ST ", "T ", "HTTP/1.0\n"};
  string method_text [0:7] = '{"CONNECT ", "GET ", "HEAD ", "OPTIONS ", "TRACE ",
                               "PATCH ", "POST ", "PUT "};

  head_event_t pending[$];
  script_row_t script[$];
  logic [DataW-1:0] req_bytes[$];

  int gap_rate = 0;
  int stall_rate = 0;
  int items_sent = 0;
  int n_requests = 0;
  int n_checked = 0;
  int n_fail = 0;
  int ev_seen [0:15];

  http_request_head_parser_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_res  (out_event_res),
    .out_out_byte   (out_out_byte),
    .out_position   (out_position),
    .out_method_code(out_method_code),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  function automatic int clamp_lim(input int v);
    return (v > int'(MaxFieldBytes)) ? int'(MaxFieldBytes) : v;
  endfunction

  function automatic logic [MethW-1:0] sel_method(input logic [3:0] sel);
    case (sel)
      SelHead:    return MethHead;
      SelOptions: return MethOptions;
      SelTrace:   return MethTrace;
      SelPatch:   return MethPatch;
      SelPost:    return MethPost;
      SelPut:     return MethPut;
      default:    return MethGet;
    endcase
  endfunction

  function automatic void open_text(input logic [3:0] sel);
    p_sel = sel;
    p_idx = '0;
    p_meth = sel_method(sel);
    p_phase = P_TEXT;
  endfunction

  // Bounded, delimited field: the delimiter needs one free place, a data byte two.
  function automatic field_verdict_t judge(input logic [DataW-1:0] c,
                                           input logic [DataW-1:0] delim,
                                           input int cnt, input int lim);
    if (cnt >= lim) return FV_ERROR;
    if (c == delim) return FV_DELIM;
    if (c == ChLf || c == ChNul) return FV_ERROR;
    if (cnt + 1 >= lim) return FV_ERROR;
    return FV_DATA;
  endfunction

  function automatic head_event_t parse_byte(input logic [DataW-1:0] c, input logic rs);
    head_event_t e;
    field_verdict_t v;
    string txt;
    int lim;
    e = '0;
    e.ev = EV_CONSUMED;
    if (rs) begin
      p_phase = P_METH0;
      p_sel = '0;
      p_idx = '0;
      p_cnt = '0;
      p_meth = MethGet;
    end
    case (p_phase)
      P_METH0: begin
        case (c)
          "C": open_text(SelConnect);
          "G": open_text(SelGet);
          "H": open_text(SelHead);
          "O": open_text(SelOptions);
          "T": open_text(SelTrace);
          "P": p_phase = P_METH1;
          default: begin
            p_phase = P_ERR;
            e.ev = EV_ERROR;
          end
        endcase
      end
      P_METH1: begin
        case (c)
          "A": open_text(SelPatch);
          "O": open_text(SelPost);
          "U": open_text(SelPut);
          default: begin
            p_phase = P_ERR;
            e.ev = EV_ERROR;
          end
        endcase
      end
      P_TEXT: begin
        txt = lit_text[p_sel];
        if (p_idx >= txt.len() || txt[p_idx] != c) begin
          p_phase = P_ERR;
          e.ev = EV_ERROR;
        end else if (p_idx + 1 == txt.len()) begin
          p_cnt = '0;
          if (p_sel == SelVersion) begin
            p_phase = P_LINE;
          end else begin
            p_phase = P_URI;
            e.ev = EV_METHOD;
          end
        end else begin
          p_idx = p_idx + 1'b1;
        end
      end
      P_URI: begin
        v = judge(c, ChSpace, p_cnt, clamp_lim(lim_uri));
        if (v == FV_ERROR) begin
          p_phase = P_ERR;
          e.ev = EV_ERROR;
        end else if (v == FV_DELIM) begin
          e.ev = EV_URI_END;
          e.pos = PosW'(p_cnt);
          p_sel = SelVersion;
          p_idx = '0;
          p_phase = P_TEXT;
        end else begin
          e.ev = EV_URI_BYTE;
          e.ob = c;
          e.pos = PosW'(p_cnt);
          p_cnt = p_cnt + 1'b1;
        end
      end
      P_LINE: begin
        if (c == ChLf) begin
          e.ev = EV_HDRS_DONE;
          p_phase = P_DONE;
        end else begin
          e.ev = EV_NAME_BYTE;
          e.ob = c;
          p_cnt = '0;
          p_phase = P_NAME;
        end
      end
      P_NAME: begin
        // The first name byte was taken on the line start, so one place less.
        lim = clamp_lim(lim_name);
        lim = (lim > 0) ? lim - 1 : 0;
        v = judge(c, ChColon, p_cnt, lim);
        if (v == FV_ERROR) begin
          p_phase = P_ERR;
          e.ev = EV_ERROR;
        end else if (v == FV_DELIM) begin
          e.ev = EV_NAME_END;
          e.pos = PosW'(p_cnt + 1);
          p_cnt = '0;
          p_phase = P_VALUE;
        end else begin
          e.ev = EV_NAME_BYTE;
          e.ob = c;
          e.pos = PosW'(p_cnt + 1);
          p_cnt = p_cnt + 1'b1;
        end
      end
      P_VALUE: begin
        v = judge(c, ChLf, p_cnt, clamp_lim(lim_value));
        if (v == FV_ERROR) begin
          p_phase = P_ERR;
          e.ev = EV_ERROR;
        end else if (v == FV_DELIM) begin
          e.ev = EV_HDR_END;
          e.pos = PosW'(p_cnt);
          p_cnt = '0;
          p_phase = P_LINE;
        end else begin
          e.ev = EV_VALUE_BYTE;
          e.ob = c;
          e.pos = PosW'(p_cnt);
          p_cnt = p_cnt + 1'b1;
        end
      end
      P_DONE: e.ev = EV_IDLE;
      default: begin
        p_phase = P_ERR;
        e.ev = EV_ERROR;
      end
    endcase
    e.meth = p_meth;
    return e;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      n_fail++;
    end
  endtask

  // Checks each result word against the oldest expectation, then predicts the
  // word taken at this edge.
  always @(posedge clk) begin : watch_words
    head_event_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          $display("%0t: unexpected word, expected none, got event %0d",
                   $time, out_event_res);
          n_fail++;
        end else begin
          want = pending.pop_front();
          check_field("event", 16'(want.ev), 16'(out_event_res));
          check_field("byte", 16'(want.ob), 16'(out_out_byte));
          check_field("position", 16'(want.pos), 16'(out_position));
          check_field("method", 16'(want.meth), 16'(out_method_code));
          n_checked++;
          ev_seen[out_event_res]++;
        end
      end
      if (in_valid && !in_stall) begin
        want = parse_byte(in_data_byte, in_restart);
        if (pin_on) want = pin_word;
        pending.push_back(want);
      end
    end
  end

  initial begin : stall_gen
    foreach (ev_seen[i]) ev_seen[i] = 0;
    forever begin
      @(posedge clk);
      if (stall_rate != 0 && $urandom_range(0, 99) < stall_rate) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("status: fail");
    $finish;
  end

  task automatic drive_byte(input logic [DataW-1:0] data, input logic rs,
                            input logic pinned, input head_event_t pw);
    if (gap_rate != 0 && $urandom_range(0, 99) < gap_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_restart <= rs;
    pin_on <= pinned;
    pin_word <= pw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drops valid and waits until every expected word has come out.
  task automatic settle();
    int guard;
    in_valid <= 1'b0;
    @(posedge clk);
    for (guard = 0; guard < 20000 && pending.size() != 0; guard++) @(posedge clk);
    if (pending.size() != 0) begin
      $display("%0t: %0d words expected but never delivered", $time, pending.size());
      n_fail += pending.size();
      pending.delete();
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LimW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    case (idx)
      CfgUriLimit:   lim_uri = val;
      CfgNameLimit:  lim_name = val[NameLimW-1:0];
      CfgValueLimit: lim_value = val;
      default: ;
    endcase
  endtask

  task automatic load_limits(input int u, input int n, input int v);
    settle();
    write_reg(CfgUriLimit, LimW'(u));
    write_reg(CfgNameLimit, LimW'(n));
    write_reg(CfgValueLimit, LimW'(v));
    // Writes to the unused index must leave the limits alone.
    write_reg(CfgSpare, LimW'($urandom_range(0, 8191)));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void row(input logic [DataW-1:0] data, input logic rs);
    script_row_t r;
    r.data = data;
    r.rs = rs;
    r.pinned = 1'b0;
    r.word = '0;
    script.push_back(r);
  endfunction

  function automatic void row_exp(input logic [DataW-1:0] data, input logic rs,
                                  input event_t ev, input logic [DataW-1:0] ob,
                                  input logic [PosW-1:0] pos,
                                  input logic [MethW-1:0] meth);
    script_row_t r;
    r.data = data;
    r.rs = rs;
    r.pinned = 1'b1;
    r.word.ev = ev;
    r.word.ob = ob;
    r.word.pos = pos;
    r.word.meth = meth;
    script.push_back(r);
  endfunction

  // Field length: mostly short, sometimes exactly full, sometimes one too many.
  function automatic int pick_len(input int room);
    int r;
    int hi;
    r = $urandom_range(0, 99);
    hi = (room < 10) ? room : 10;
    if (hi < 0) hi = 0;
    if (room <= 300 && r < 6) return (room + 1 > 0) ? room + 1 : 0;
    if (room <= 300 && r < 14) return (room > 0) ? room : 0;
    return $urandom_range(0, hi);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endfunction

  function automatic void add_plain(input int n, input logic [DataW-1:0] delim);
    logic [DataW-1:0] b;
    repeat (n) begin
      do b = $urandom_range(0, 255); while (b == ChLf || b == ChNul || b == delim);
      req_bytes.push_back(b);
    end
  endfunction

  // One request head, mostly well formed; uri_len below zero picks a length.
  task automatic send_request(input int uri_len);
    int n;
    int cut;
    int i;
    int name_room;
    req_bytes.delete();
    n_requests++;
    name_room = (lim_name == 0) ? -1 : int'(lim_name) - 2;
    if ($urandom_range(0, 99) < 5) begin
      repeat ($urandom_range(1, 6)) req_bytes.push_back($urandom_range(0, 255));
    end else begin
      add_text(method_text[$urandom_range(0, 7)]);
      if (uri_len < 0) uri_len = pick_len(clamp_lim(lim_uri) - 1);
      add_plain(uri_len, ChSpace);
      req_bytes.push_back(ChSpace);
      add_text(lit_text[SelVersion]);
      repeat ($urandom_range(0, 3)) begin
        // A header line starts with any byte now and then, colon and NUL included.
        if ($urandom_range(0, 9) == 0) req_bytes.push_back($urandom_range(0, 255));
        else req_bytes.push_back($urandom_range(8'h61, 8'h7a));
        add_plain(pick_len(name_room), ChColon);
        req_bytes.push_back(ChColon);
        add_plain(pick_len(clamp_lim(lim_value) - 1), ChLf);
        req_bytes.push_back(ChLf);
      end
      req_bytes.push_back(ChLf);
      repeat ($urandom_range(0, 2)) req_bytes.push_back($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) begin
        i = $urandom_range(0, req_bytes.size() - 1);
        if ($urandom_range(0, 3) == 0) req_bytes[i] = $urandom_range(0, 1) ? ChLf : ChNul;
        else req_bytes[i] = $urandom_range(0, 255);
      end
    end
    cut = -1;
    if (req_bytes.size() > 1 && $urandom_range(0, 19) == 0)
      cut = $urandom_range(1, req_bytes.size() - 1);
    for (i = 0; i < req_bytes.size(); i++)
      drive_byte(req_bytes[i], (i == 0 || i == cut), 1'b0, '0);
  endtask

  initial begin : stimulus
    int set_base;
    string ver;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset limits.
    row_exp("X", 1'b0, EV_ERROR, 8'h00, 12'd0, MethGet);
    row_exp("G", 1'b0, EV_ERROR, 8'h00, 12'd0, MethGet);
    row_exp("P", 1'b1, EV_CONSUMED, 8'h00, 12'd0, MethGet);
    row_exp("Z", 1'b0, EV_ERROR, 8'h00, 12'd0, MethGet);
    row_exp("P", 1'b1, EV_CONSUMED, 8'h00, 12'd0, MethGet);
    row_exp("U", 1'b0, EV_CONSUMED, 8'h00, 12'd0, MethPut);
    row_exp("T", 1'b0, EV_CONSUMED, 8'h00, 12'd0, MethPut);
    row_exp(" ", 1'b0, EV_METHOD, 8'h00, 12'd0, MethPut);
    row_exp(8'hFF, 1'b0, EV_URI_BYTE, 8'hFF, 12'd0, MethPut);
    row_exp(" ", 1'b0, EV_URI_END, 8'h00, 12'd1, MethPut);
    ver = lit_text[SelVersion];
    for (int i = 0; i < ver.len(); i++) row(ver[i], 1'b0);
    row_exp(":", 1'b0, EV_NAME_BYTE, ":", 12'd0, MethPut);
    row_exp(":", 1'b0, EV_NAME_END, 8'h00, 12'd1, MethPut);
    row_exp(ChNul, 1'b0, EV_ERROR, 8'h00, 12'd0, MethPut);
    row_exp("C", 1'b1, EV_CONSUMED, 8'h00, 12'd0, MethGet);
    row_exp(ChLf, 1'b0, EV_ERROR, 8'h00, 12'd0, MethGet);
    row_exp("O", 1'b1, EV_CONSUMED, 8'h00, 12'd0, MethOptions);
    row_exp("T", 1'b1, EV_CONSUMED, 8'h00, 12'd0, MethTrace);
    row_exp("H", 1'b1, EV_CONSUMED, 8'h00, 12'd0, MethHead);

    gap_rate = 20;
    stall_rate = 20;
    foreach (script[i]) drive_byte(script[i].data, script[i].rs, script[i].pinned,
                                   script[i].word);

    for (int s = 0; s < NumSets; s++) begin
      case (s)
        0: load_limits(2, 2, 1);
        1: load_limits(8191, 511, 8191);
        2: load_limits(1, 0, 0);
        3: load_limits(3, 3, 0);
        4: load_limits(4096, 256, 4096);
        default: load_limits($urandom_range(2, 24), $urandom_range(2, 16),
                             $urandom_range(1, 24));
      endcase
      set_base = items_sent;
      while (items_sent - set_base < WordsPerSet) begin
        if (s == NumSets - 1) begin
          gap_rate = 0;
          stall_rate = 0;
        end else begin
          gap_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
          stall_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
        end
        send_request(-1);
      end
    end

    settle();
    $display("Checked %0d words from %0d requests over %0d limit settings.",
             n_checked, n_requests, NumSets + 1);
    $display("Seen: %0d methods, %0d header lines, %0d complete heads, %0d errors, %0d idle.",
             ev_seen[EV_METHOD], ev_seen[EV_HDR_END], ev_seen[EV_HDRS_DONE],
             ev_seen[EV_ERROR], ev_seen[EV_IDLE]);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/hdp_pkg.sv
rtl/core/hdp_field_check.sv
rtl/core/http_request_head_parser_core.sv
tb/tb.sv
